/* hw/rtl/efm_pkg.sv */
`default_nettype none
package efm_pkg;

    localparam int MAX_DEGREE = 8;
    localparam int COEFF_BITS = 8;
    localparam int DEG_BITS = 4;
    localparam int LANE_BITS = 3;
    // Widest unreduced lane sum is q-1 + 2(q-1)^2, below 2^17 for 8-bit q.
    localparam int SUM_BITS = 17;
    localparam int RECIP_SHIFT = 17;
    localparam int DIV_STEPS = RECIP_SHIFT + 1;
    localparam int CNT_BITS = 5;
    localparam int CELL_LATENCY = 3;

    localparam logic [COEFF_BITS-1:0] PRIME_RESET = COEFF_BITS'(3);
    localparam logic [DEG_BITS-1:0] DEGREE_RESET = DEG_BITS'(4);
    localparam logic [63:0] MODULUS_RESET = 64'd33554434;
    localparam logic [SUM_BITS-1:0] RECIP_RESET = SUM_BITS'((1 << RECIP_SHIFT) / 3);

    typedef logic [MAX_DEGREE-1:0][COEFF_BITS-1:0] coeff_vec_t;

    typedef struct packed {
        logic valid;
        logic zero;
        logic [DEG_BITS-1:0] deg;
    } item_ctl_t;

    typedef enum logic [1:0] {
        REG_PRIME   = 2'd0,
        REG_DEGREE  = 2'd1,
        REG_MODULUS = 2'd2,
        REG_NONE    = 2'd3
    } cfg_reg_t;

endpackage
`default_nettype wire

/* hw/rtl/extension_field_multiplier.sv */
`default_nettype none
// An accepted item passes input reduction, eight Horner cells and one output register
// before its product appears.
// Throughput: one item per cycle; the whole pipeline holds while the product waits.
// A write of the prime register runs the reciprocal divider, during which in_stall is high.
// Reset (rst_n, asynchronous) loads q = 3, n = 4, modulus x^4 + 2x^3 + 2 and empties the pipe.
module extension_field_multiplier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [63:0] product,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [efm_pkg::COEFF_BITS-1:0] prime_reg;
    logic [efm_pkg::DEG_BITS-1:0]   degree_reg;
    logic [63:0]                    modulus_reg;
    logic [efm_pkg::SUM_BITS-1:0]   recip_reg;
    logic [efm_pkg::SUM_BITS-1:0]   quo_reg;
    logic [efm_pkg::COEFF_BITS-1:0] rem_reg;
    logic [efm_pkg::CNT_BITS-1:0]   cnt_reg;
    logic                           busy_reg;
    logic [efm_pkg::COEFF_BITS:0]   rem_sh;
    logic                           ge;
    logic                           cfg_we;

    logic                           en;
    logic [efm_pkg::DEG_BITS-1:0]   deg_eff;
    efm_pkg::item_ctl_t             ctl_in, ctl_p1_reg, ctl_p2_reg;
    efm_pkg::coeff_vec_t            a_red, b_red, m_red, nm0;
    logic                           out_valid_reg;
    logic [63:0]                    product_reg;

    efm_pkg::item_ctl_t  ctl_c [efm_pkg::MAX_DEGREE+1];
    efm_pkg::coeff_vec_t a_c   [efm_pkg::MAX_DEGREE+1];
    efm_pkg::coeff_vec_t b_c   [efm_pkg::MAX_DEGREE+1];
    efm_pkg::coeff_vec_t nm_c  [efm_pkg::MAX_DEGREE+1];
    efm_pkg::coeff_vec_t acc_c [efm_pkg::MAX_DEGREE+1];

    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= efm_pkg::PRIME_RESET;
            degree_reg <= efm_pkg::DEGREE_RESET;
            modulus_reg <= efm_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (efm_pkg::cfg_reg_t'(cfg_index))
                efm_pkg::REG_PRIME:   prime_reg <= cfg_data[efm_pkg::COEFF_BITS-1:0];
                efm_pkg::REG_DEGREE:  degree_reg <= cfg_data[efm_pkg::DEG_BITS-1:0];
                efm_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Restoring division of 2^17 by q, one quotient bit per cycle.
    always_comb
    begin
        rem_sh = {rem_reg, (cnt_reg == efm_pkg::CNT_BITS'(efm_pkg::DIV_STEPS - 1))};
        ge = rem_sh >= {1'b0, prime_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            recip_reg <= efm_pkg::RECIP_RESET;
        end
        else if (cfg_we && efm_pkg::cfg_reg_t'(cfg_index) == efm_pkg::REG_PRIME)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= efm_pkg::CNT_BITS'(efm_pkg::DIV_STEPS - 1);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? efm_pkg::COEFF_BITS'(rem_sh - {1'b0, prime_reg})
                          : rem_sh[efm_pkg::COEFF_BITS-1:0];
            quo_reg <= {quo_reg[efm_pkg::SUM_BITS-2:0], ge};
            cnt_reg <= cnt_reg - efm_pkg::CNT_BITS'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                recip_reg <= {quo_reg[efm_pkg::SUM_BITS-2:0], ge};
            end
        end
    end

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = busy_reg || !en;

    always_comb
    begin
        deg_eff = (degree_reg > efm_pkg::DEG_BITS'(efm_pkg::MAX_DEGREE))
                ? efm_pkg::DEG_BITS'(efm_pkg::MAX_DEGREE) : degree_reg;
        ctl_in.valid = in_valid && !in_stall;
        ctl_in.zero = (deg_eff == '0) || (prime_reg < efm_pkg::COEFF_BITS'(2));
        ctl_in.deg = deg_eff;
    end

    for (genvar j = 0; j < efm_pkg::MAX_DEGREE; j++)
    begin : g_prep
        logic [efm_pkg::SUM_BITS-1:0] xa, xb, xm;
        logic                         used;

        assign used = efm_pkg::DEG_BITS'(j) < deg_eff;
        assign xa = used ? efm_pkg::SUM_BITS'(operand_a[efm_pkg::COEFF_BITS*j +:
                                                        efm_pkg::COEFF_BITS]) : '0;
        assign xb = used ? efm_pkg::SUM_BITS'(operand_b[efm_pkg::COEFF_BITS*j +:
                                                        efm_pkg::COEFF_BITS]) : '0;
        assign xm = used ? efm_pkg::SUM_BITS'(modulus_reg[efm_pkg::COEFF_BITS*j +:
                                                          efm_pkg::COEFF_BITS]) : '0;

        efm_modq u_ra (.clk(clk), .en(en), .x(xa), .recip(recip_reg), .q(prime_reg),
                       .y(a_red[j]));
        efm_modq u_rb (.clk(clk), .en(en), .x(xb), .recip(recip_reg), .q(prime_reg),
                       .y(b_red[j]));
        efm_modq u_rm (.clk(clk), .en(en), .x(xm), .recip(recip_reg), .q(prime_reg),
                       .y(m_red[j]));

        // x^n = -sum m_k x^k, so the cells add multiples of q - m_k.
        assign nm0[j] = (m_red[j] == '0) ? '0 : prime_reg - m_red[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_p1_reg <= '0;
            ctl_p2_reg <= '0;
        end
        else if (en)
        begin
            ctl_p1_reg <= ctl_in;
            ctl_p2_reg <= ctl_p1_reg;
        end
    end

    assign ctl_c[0] = ctl_p2_reg;
    assign a_c[0] = a_red;
    assign b_c[0] = b_red;
    assign nm_c[0] = nm0;
    assign acc_c[0] = '0;

    for (genvar i = 0; i < efm_pkg::MAX_DEGREE; i++)
    begin : g_cell
        efm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .recip   (recip_reg),
            .q       (prime_reg),
            .ctl_in  (ctl_c[i]),
            .a_in    (a_c[i]),
            .b_in    (b_c[i]),
            .nm_in   (nm_c[i]),
            .acc_in  (acc_c[i]),
            .ctl_out (ctl_c[i+1]),
            .a_out   (a_c[i+1]),
            .b_out   (b_c[i+1]),
            .nm_out  (nm_c[i+1]),
            .acc_out (acc_c[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_c[efm_pkg::MAX_DEGREE].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= ctl_c[efm_pkg::MAX_DEGREE].zero ? 64'd0
                                                           : acc_c[efm_pkg::MAX_DEGREE];
        end
    end

    assign out_valid = out_valid_reg;
    assign product = product_reg;

    // No item may enter while the reciprocal is being recomputed.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("item accepted during reciprocal update");

    // A write of the prime always starts the divider.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == efm_pkg::REG_PRIME) |=> busy_reg)
        else $error("divider did not start after prime write");

    // Once settled, the reciprocal is floor(2^17 / q).
    a_recip_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && prime_reg >= efm_pkg::COEFF_BITS'(2)) |->
        ((26'(recip_reg) * 26'(prime_reg) <= 26'(1 << efm_pkg::RECIP_SHIFT)) &&
         (26'(recip_reg) * 26'(prime_reg) + 26'(prime_reg) >
          26'(1 << efm_pkg::RECIP_SHIFT))))
        else $error("reciprocal out of range");

    // A degenerate field gives a zero product.
    a_zero_field: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (degree_reg == '0 || prime_reg < efm_pkg::COEFF_BITS'(2)))
        |-> (product_reg == 64'd0))
        else $error("nonzero product for degenerate field");

endmodule
`default_nettype wire

/* hw/rtl/efm_modq.sv */
`default_nettype none
// Two-stage Barrett reduction of a lane value modulo q.
module efm_modq (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [efm_pkg::SUM_BITS-1:0]    x,
    input  wire logic [efm_pkg::SUM_BITS-1:0]    recip,
    input  wire logic [efm_pkg::COEFF_BITS-1:0]  q,
    output logic      [efm_pkg::COEFF_BITS-1:0]  y
);

    logic [2*efm_pkg::SUM_BITS-1:0] prod_reg;
    logic [efm_pkg::SUM_BITS-1:0]   x_reg;
    logic [efm_pkg::COEFF_BITS-1:0] y_reg;
    logic [efm_pkg::COEFF_BITS-1:0] y_next;
    logic [efm_pkg::SUM_BITS-1:0]   est;
    logic [efm_pkg::SUM_BITS+efm_pkg::COEFF_BITS-1:0] eq;
    logic [efm_pkg::SUM_BITS-1:0]   rem;
    logic [efm_pkg::SUM_BITS-1:0]   q_ext;

    always_comb
    begin
        est = prod_reg[2*efm_pkg::SUM_BITS-1:efm_pkg::RECIP_SHIFT];
        eq = est * q;
        q_ext = {{(efm_pkg::SUM_BITS-efm_pkg::COEFF_BITS){1'b0}}, q};
        // The quotient estimate is low by at most one, so one subtract corrects it.
        rem = x_reg - eq[efm_pkg::SUM_BITS-1:0];
        if (rem >= q_ext)
        begin
            rem = rem - q_ext;
        end
        y_next = rem[efm_pkg::COEFF_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= x * recip;
            x_reg <= x;
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule
`default_nettype wire

/* hw/rtl/efm_cell.sv */
`default_nettype none
// One Horner step: acc = acc * x mod (modulus, q) + a_top * b.
module efm_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic [efm_pkg::SUM_BITS-1:0]    recip,
    input  wire logic [efm_pkg::COEFF_BITS-1:0]  q,
    input  wire efm_pkg::item_ctl_t              ctl_in,
    input  wire efm_pkg::coeff_vec_t             a_in,
    input  wire efm_pkg::coeff_vec_t             b_in,
    input  wire efm_pkg::coeff_vec_t             nm_in,
    input  wire efm_pkg::coeff_vec_t             acc_in,
    output efm_pkg::item_ctl_t                   ctl_out,
    output efm_pkg::coeff_vec_t                  a_out,
    output efm_pkg::coeff_vec_t                  b_out,
    output efm_pkg::coeff_vec_t                  nm_out,
    output efm_pkg::coeff_vec_t                  acc_out
);

    logic [efm_pkg::MAX_DEGREE-1:0][efm_pkg::SUM_BITS-1:0] s_next;
    logic [efm_pkg::MAX_DEGREE-1:0][efm_pkg::SUM_BITS-1:0] s_reg;
    logic [efm_pkg::DEG_BITS-1:0]   deg_m1;
    logic [efm_pkg::COEFF_BITS-1:0] top;
    logic [efm_pkg::COEFF_BITS-1:0] a_top;
    logic [efm_pkg::COEFF_BITS-1:0] sh;

    efm_pkg::item_ctl_t  ctl1_reg, ctl2_reg, ctl3_reg;
    efm_pkg::coeff_vec_t a1_reg, a2_reg, a3_reg;
    efm_pkg::coeff_vec_t b1_reg, b2_reg, b3_reg;
    efm_pkg::coeff_vec_t nm1_reg, nm2_reg, nm3_reg;

    always_comb
    begin
        deg_m1 = ctl_in.deg - efm_pkg::DEG_BITS'(1);
        top = acc_in[deg_m1[efm_pkg::LANE_BITS-1:0]];
        a_top = a_in[efm_pkg::MAX_DEGREE-1];
        for (int j = 0; j < efm_pkg::MAX_DEGREE; j++)
        begin
            sh = '0;
            if (j != 0 && efm_pkg::DEG_BITS'(j) < ctl_in.deg)
            begin
                sh = acc_in[j-1];
            end
            s_next[j] = efm_pkg::SUM_BITS'(sh)
                      + efm_pkg::SUM_BITS'(top * nm_in[j])
                      + efm_pkg::SUM_BITS'(a_top * b_in[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
            // The next cell takes the next lower coefficient of a from the top slot.
            a1_reg <= {a_in[efm_pkg::MAX_DEGREE-2:0], efm_pkg::COEFF_BITS'(0)};
            a2_reg <= a1_reg;
            a3_reg <= a2_reg;
            b1_reg <= b_in;
            b2_reg <= b1_reg;
            b3_reg <= b2_reg;
            nm1_reg <= nm_in;
            nm2_reg <= nm1_reg;
            nm3_reg <= nm2_reg;
        end
    end

    for (genvar j = 0; j < efm_pkg::MAX_DEGREE; j++)
    begin : g_lane
        efm_modq u_modq (
            .clk   (clk),
            .en    (en),
            .x     (s_reg[j]),
            .recip (recip),
            .q     (q),
            .y     (acc_out[j])
        );
    end

    assign ctl_out = ctl3_reg;
    assign a_out = a3_reg;
    assign b_out = b3_reg;
    assign nm_out = nm3_reg;

endmodule
`default_nettype wire

/* dv/tb_extension_field_multiplier.sv */
`timescale 1ns / 100ps
module tb_extension_field_multiplier;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int NUM_ROWS = 10;

    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
        logic        has_known;
        logic [63:0] known;
    } mul_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] product;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // The testbench's copy of the configuration registers.
    logic [7:0]  cur_prime;
    logic [3:0]  cur_degree;
    logic [63:0] cur_modulus;

    logic [63:0] expected_products[$];
    int          error_count;
    int          cycle_count;
    bit          stall_enable;
    bit          valid_gaps;
    mul_row_t    rows[NUM_ROWS];

    extension_field_multiplier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .product   (product),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] field_multiply(logic [63:0] a, logic [63:0] b);
        int unsigned q;
        int unsigned n;
        int unsigned ca[efm_pkg::MAX_DEGREE];
        int unsigned cb[efm_pkg::MAX_DEGREE];
        int unsigned cm[efm_pkg::MAX_DEGREE];
        int unsigned acc[2*efm_pkg::MAX_DEGREE];
        int unsigned lead;
        logic [63:0] res;
        q = cur_prime;
        n = (cur_degree > efm_pkg::MAX_DEGREE) ? efm_pkg::MAX_DEGREE : cur_degree;
        res = '0;
        if (n == 0 || q < 2)
            return res;
        for (int i = 0; i < 2*efm_pkg::MAX_DEGREE; i++)
            acc[i] = 0;
        for (int i = 0; i < n; i++)
        begin
            ca[i] = a[8*i +: 8] % q;
            cb[i] = b[8*i +: 8] % q;
            cm[i] = cur_modulus[8*i +: 8] % q;
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                acc[i+j] = (acc[i+j] + ca[i] * cb[j]) % q;
        // Fold each high term back using x^n = -(m[n-1] x^(n-1) + ... + m[0]).
        for (int d = 2*n - 2; d >= int'(n); d--)
        begin
            lead = acc[d];
            acc[d] = 0;
            for (int j = 0; j < n; j++)
                acc[d-n+j] = (acc[d-n+j] + lead * ((q - cm[j]) % q)) % q;
        end
        for (int i = 0; i < n; i++)
            res[8*i +: 8] = acc[i][7:0];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operands biased toward coefficients near q and toward all-ones or zero bytes.
    function automatic logic [63:0] shaped_operand();
        logic [63:0] v;
        v = rand64();
        for (int i = 0; i < 8; i++)
            case ($urandom_range(0, 7))
                0: v[8*i +: 8] = 8'h00;
                1: v[8*i +: 8] = 8'hFF;
                2: v[8*i +: 8] = (cur_prime == 0) ? 8'h00 : cur_prime - 8'd1;
                3: v[8*i +: 8] = cur_prime;
                default: ;
            endcase
        return v;
    endfunction

    task automatic write_register(efm_pkg::cfg_reg_t idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            efm_pkg::REG_PRIME:   cur_prime = data[7:0];
            efm_pkg::REG_DEGREE:  cur_degree = data[3:0];
            efm_pkg::REG_MODULUS: cur_modulus = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Valid stays high after an item is accepted so that the next item can follow
    // in the very next cycle; wait_idle drops it.
    task automatic send_multiply(logic [63:0] a, logic [63:0] b, logic has_known,
                                 logic [63:0] known);
        @(negedge clk);
        while (valid_gaps && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_products.insert(expected_products.size(),
                                 has_known ? known : field_multiply(a, b));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++)
            send_multiply(($urandom_range(0, 3) == 0) ? rand64() : shaped_operand(),
                          shaped_operand(), 1'b0, '0);
    endtask

    task automatic apply_setting(logic [7:0] q, logic [3:0] n, logic [63:0] m);
        wait_idle();
        write_register(efm_pkg::REG_PRIME, {56'd0, q});
        write_register(efm_pkg::REG_DEGREE, {60'd0, n});
        write_register(efm_pkg::REG_MODULUS, m);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_products.size() == 0)
            begin
                $display("%0t: unexpected product %h", $time, product);
                error_count++;
            end
            else
            begin
                logic [63:0] want;
                want = expected_products.pop_front();
                if (product !== want)
                begin
                    $display("%0t: product expected %h actual %h", $time, want, product);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= stall_enable && ($urandom_range(0, 99) < 38);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operand_a = '0;
        operand_b = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = efm_pkg::REG_PRIME;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        stall_enable = 1'b0;
        valid_gaps = 1'b0;
        cur_prime = 8'd3;
        cur_degree = 4'd4;
        cur_modulus = 64'd33554434;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Rows under the reset setting: q = 3, n = 4, x^4 + 2x^3 + 2.
        rows = '{
            '{64'h0, 64'h0, 1'b1, 64'h0},
            '{64'h1, 64'h1, 1'b1, 64'h1},
            '{64'h1, 64'h0000000002010201, 1'b1, 64'h0000000002010201},
            '{64'hFFFFFFFF_FFFFFFFF, 64'h0, 1'b1, 64'h0},
            '{64'h3, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 64'h0},
            '{64'h0000000000000100, 64'h0000000001000000, 1'b0, 64'h0},
            '{64'h0000000001000000, 64'h0000000001000000, 1'b0, 64'h0},
            '{64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 1'b0, 64'h0},
            '{64'hAAAAAAAA_AAAAAAAA, 64'h55555555_55555555, 1'b0, 64'h0},
            '{64'h0000000002020202, 64'h0000000002020202, 1'b0, 64'h0}
        };
        foreach (rows[r])
            send_multiply(rows[r].a, rows[r].b, rows[r].has_known, rows[r].known);

        // Degenerate primes and degree zero give zero products.
        apply_setting(8'd0, 4'd4, 64'h0000000002000002);
        send_multiply(64'h0102030405060708, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 64'h0);
        apply_setting(8'd1, 4'd8, 64'h0);
        send_multiply(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 64'h0);
        apply_setting(8'd7, 4'd0, 64'h0);
        send_multiply(64'h0102030405060708, 64'h0102030405060708, 1'b1, 64'h0);
        // Degree above the maximum saturates; composite q and unreduced modulus.
        apply_setting(8'd251, 4'd15, 64'hFFFFFFFF_FFFFFFFF);
        send_multiply(64'hFFFFFFFF_FFFFFFFF, 64'hFAFAFAFA_FAFAFAFA, 1'b0, '0);
        send_multiply(64'h1, 64'hFFFFFFFF_FFFFFFFF, 1'b0, '0);
        apply_setting(8'd2, 4'd1, 64'hFFFFFFFF_FFFFFFFF);
        send_multiply(64'h1, 64'h1, 1'b1, 64'h1);
        send_multiply(64'h3, 64'h2, 1'b1, 64'h0);
        apply_setting(8'd255, 4'd8, 64'hFE);
        send_multiply(64'hFFFFFFFF_FFFFFFFF, 64'hFEFEFEFE_FEFEFEFE, 1'b0, '0);
        apply_setting(8'd12, 4'd3, 64'h0000000000000B05);
        send_multiply(64'h0000000000FF0B0C, 64'h0000000000070B01, 1'b0, '0);

        // Random phase: a stretch with no idling first, then idling on both sides.
        apply_setting(8'd251, 4'd8, rand64());
        run_random(80);
        stall_enable = 1'b1;
        valid_gaps = 1'b1;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase % 5)
                0: apply_setting(8'd251, 4'd8, rand64());
                1: apply_setting(8'd2, 4'($urandom_range(1, 8)), rand64());
                2: apply_setting(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                 rand64());
                3: apply_setting(8'd3, 4'd1, rand64());
                default: apply_setting(8'($urandom_range(2, 251)),
                                       4'($urandom_range(1, 8)), rand64());
            endcase
            run_random(62);
        end

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
